### src/tlpi_pkg.sv
package tlpi_pkg;

	localparam int QUEUE_DEPTH = 256;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = PTR_W + 1;
	localparam int PAYLOAD_W = 32;
	localparam int TIME_W = 63;
	localparam int DEPTH_W = 10;
	localparam int IVL_W = 40;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = IVL_W;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_WMARK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FAIR_IVL = 2'd2;

	localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST = 10'd768;
	localparam logic [DEPTH_W-1:0] LOW_WMARK_RST = 10'd614;
	localparam logic [IVL_W-1:0] FAIR_IVL_RST = 40'd100000000;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP = 1'b1;

	localparam logic [1:0] LVL_HIGH = 2'd0;
	localparam logic [1:0] LVL_NORMAL = 2'd1;
	localparam logic [1:0] LVL_LOW = 2'd2;
	localparam logic [1:0] PRIO_INVALID = 2'd3;

	typedef struct packed {
		logic [DEPTH_W-1:0] max_total_depth;
		logic [DEPTH_W-1:0] clear_depth;
		logic [IVL_W-1:0] fairness_interval;
	} cfg_t;

	typedef struct packed {
		logic func;
		logic [1:0] lvl;
		logic [PAYLOAD_W-1:0] payload;
		logic [TIME_W-1:0] now_time;
	} item_t;

endpackage

### src/three_level_priority_inbox.sv
// Channel   Handshake               Beat contents
// input     in_valid / in_ready     func, priority_req, payload, now_time
// output    out_valid / out_ready   accepted, got_item, out_payload, out_priority,
//                                   overload, depth_total
// config    cfg_we                  cfg_index, cfg_data
//
// In the execution stage ST_EXEC decides and updates the queue state while the
// three payload memories are read; ST_FIN then forms the result.
// A two-entry queue sits between the input side and the execution stage.
// A stalled output holds the execution stage; the input keeps taking beats until
// the two-entry queue is full.
// Reset clears all counts, heads, the last service time and the overload flag; no sweep.
module three_level_priority_inbox import tlpi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic func,
	input logic [1:0] priority_req,
	input logic [PAYLOAD_W-1:0] payload,
	input logic [TIME_W-1:0] now_time,
	output logic out_valid,
	input logic out_ready,
	output logic accepted,
	output logic got_item,
	output logic [PAYLOAD_W-1:0] out_payload,
	output logic [1:0] out_priority,
	output logic overload,
	output logic [DEPTH_W-1:0] depth_total
);

	cfg_t cfg_q;
	logic q_valid;
	item_t q_item;
	logic q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_total_depth <= MAX_DEPTH_RST;
			cfg_q.clear_depth <= LOW_WMARK_RST;
			cfg_q.fairness_interval <= FAIR_IVL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_DEPTH: cfg_q.max_total_depth <= cfg_data[DEPTH_W-1:0];
				CFG_LOW_WMARK: cfg_q.clear_depth <= cfg_data[DEPTH_W-1:0];
				CFG_FAIR_IVL: cfg_q.fairness_interval <= cfg_data[IVL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tlpi_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.priority_req(priority_req),
		.payload(payload),
		.now_time(now_time),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop)
	);

	tlpi_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.accepted(accepted),
		.got_item(got_item),
		.out_payload(out_payload),
		.out_priority(out_priority),
		.overload(overload),
		.depth_total(depth_total)
	);

endmodule

### src/tlpi_front.sv
module tlpi_front import tlpi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic func,
	input logic [1:0] priority_req,
	input logic [PAYLOAD_W-1:0] payload,
	input logic [TIME_W-1:0] now_time,
	output logic q_valid,
	output item_t q_item,
	input logic q_pop
);

	item_t fq_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic push;
	item_t cls;

	always_comb begin
		cls.func = func;
		cls.payload = payload;
		cls.now_time = now_time;
		case (priority_req) inside
			PRIO_INVALID: cls.lvl = LVL_NORMAL;
			default: cls.lvl = priority_req;
		endcase
	end

	assign in_ready = (count_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (count_q != 2'd0);
	assign q_item = fq_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fq_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

### src/tlpi_back.sv
module tlpi_back import tlpi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic q_valid,
	input item_t q_item,
	output logic q_pop,
	output logic out_valid,
	input logic out_ready,
	output logic accepted,
	output logic got_item,
	output logic [PAYLOAD_W-1:0] out_payload,
	output logic [1:0] out_priority,
	output logic overload,
	output logic [DEPTH_W-1:0] depth_total
);

	typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_FIN} state_t;

	state_t state_q;
	item_t item_q;
	logic [TIME_W:0] diff_q;
	logic [TIME_W-1:0] last_q;
	logic [PTR_W-1:0] head_q [3];
	logic [CNT_W-1:0] cnt_q [3];
	logic [DEPTH_W-1:0] total_q;
	logic ovl_q;
	logic res_acc_q;
	logic res_got_q;
	logic [1:0] res_lvl_q;
	logic move_q;
	logic [PTR_W-1:0] move_addr_q;

	logic [PAYLOAD_W-1:0] mem_hi [QUEUE_DEPTH];
	logic [PAYLOAD_W-1:0] mem_no [QUEUE_DEPTH];
	logic [PAYLOAD_W-1:0] mem_lo [QUEUE_DEPTH];
	logic [PAYLOAD_W-1:0] rd_hi_q;
	logic [PAYLOAD_W-1:0] rd_no_q;
	logic [PAYLOAD_W-1:0] rd_lo_q;

	logic out_valid_q;
	logic acc_q;
	logic got_q;
	logic [PAYLOAD_W-1:0] opay_q;
	logic [1:0] oprio_q;
	logic oovl_q;
	logic [DEPTH_W-1:0] odepth_q;

	logic out_free;
	logic exec;
	logic is_push;
	logic nz0, nz1, nz2;
	logic fair;
	logic pop_got;
	logic pop_move;
	logic [1:0] pop_lvl;
	logic full_total;
	logic psh_ok;
	logic [PTR_W-1:0] push_addr;
	logic push_we;
	logic move_we;
	logic [PAYLOAD_W-1:0] sel_pay;

	assign out_free = !out_valid_q || out_ready;
	assign q_pop = q_valid && ((state_q == ST_IDLE) || ((state_q == ST_FIN) && out_free));
	assign exec = (state_q == ST_EXEC);
	assign is_push = (item_q.func == FUNC_PUSH);
	assign nz0 = (cnt_q[0] != '0);
	assign nz1 = (cnt_q[1] != '0);
	assign nz2 = (cnt_q[2] != '0);

	// The borrow bit of the difference flags time running backwards.
	assign fair = (last_q != '0) && !diff_q[TIME_W]
		&& (diff_q[TIME_W-1:0] >= TIME_W'(cfg.fairness_interval));

	always_comb begin
		pop_got = 1'b0;
		pop_move = 1'b0;
		pop_lvl = LVL_HIGH;
		if (nz0) begin
			pop_got = 1'b1;
			if (fair && (nz1 || nz2)) begin
				pop_move = 1'b1;
				pop_lvl = nz1 ? LVL_NORMAL : LVL_LOW;
			end
		end else if (nz1) begin
			pop_got = 1'b1;
			pop_lvl = LVL_NORMAL;
		end else if (nz2) begin
			pop_got = 1'b1;
			pop_lvl = LVL_LOW;
		end
	end

	assign full_total = (total_q >= cfg.max_total_depth);
	assign psh_ok = !full_total && !cnt_q[item_q.lvl][CNT_W-1];
	assign push_addr = head_q[item_q.lvl] + cnt_q[item_q.lvl][PTR_W-1:0];
	assign push_we = exec && is_push && psh_ok;
	assign move_we = (state_q == ST_FIN) && move_q && out_free;

	always_comb begin
		case (res_lvl_q)
			LVL_HIGH: sel_pay = rd_hi_q;
			LVL_NORMAL: sel_pay = rd_no_q;
			default: sel_pay = rd_lo_q;
		endcase
		if (!res_got_q) begin
			sel_pay = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_we && (item_q.lvl == LVL_HIGH)) begin
			mem_hi[push_addr] <= item_q.payload;
		end else if (move_we) begin
			mem_hi[move_addr_q] <= rd_hi_q;
		end
		if (exec) begin
			rd_hi_q <= mem_hi[head_q[0]];
		end
	end

	always_ff @(posedge clk) begin
		if (push_we && (item_q.lvl == LVL_NORMAL)) begin
			mem_no[push_addr] <= item_q.payload;
		end
		if (exec) begin
			rd_no_q <= mem_no[head_q[1]];
		end
	end

	always_ff @(posedge clk) begin
		if (push_we && (item_q.lvl == LVL_LOW)) begin
			mem_lo[push_addr] <= item_q.payload;
		end
		if (exec) begin
			rd_lo_q <= mem_lo[head_q[2]];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
			diff_q <= {1'b0, q_item.now_time} - {1'b0, last_q};
		end
		if (exec) begin
			res_acc_q <= is_push && psh_ok;
			res_got_q <= !is_push && pop_got;
			res_lvl_q <= pop_lvl;
			move_q <= !is_push && pop_move;
			move_addr_q <= head_q[0] + cnt_q[0][PTR_W-1:0];
		end
		if ((state_q == ST_FIN) && out_free) begin
			acc_q <= res_acc_q;
			got_q <= res_got_q;
			opay_q <= sel_pay;
			oprio_q <= res_got_q ? res_lvl_q : LVL_HIGH;
			oovl_q <= ovl_q;
			odepth_q <= total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q <= '0;
			total_q <= '0;
			ovl_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				head_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end else begin
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (is_push) begin
						if (full_total) begin
							ovl_q <= 1'b1;
						end else begin
							if (total_q < cfg.clear_depth) begin
								ovl_q <= 1'b0;
							end
							if (psh_ok) begin
								cnt_q[item_q.lvl] <= cnt_q[item_q.lvl] + CNT_W'(1);
								total_q <= total_q + DEPTH_W'(1);
							end
						end
					end else if (pop_got) begin
						last_q <= item_q.now_time;
						total_q <= total_q - DEPTH_W'(1);
						cnt_q[pop_lvl] <= cnt_q[pop_lvl] - CNT_W'(1);
						head_q[pop_lvl] <= head_q[pop_lvl] + PTR_W'(1);
						if (pop_move) begin
							head_q[0] <= head_q[0] + PTR_W'(1);
						end
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= q_valid ? ST_EXEC : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign accepted = acc_q;
	assign got_item = got_q;
	assign out_payload = opay_q;
	assign out_priority = oprio_q;
	assign overload = oovl_q;
	assign depth_total = odepth_q;

endmodule

### test/three_level_priority_inbox_checker.sv
`timescale 1ns / 100ps

module three_level_priority_inbox_checker import tlpi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	input logic in_ready,
	input logic func,
	input logic [1:0] priority_req,
	input logic [PAYLOAD_W-1:0] payload,
	input logic [TIME_W-1:0] now_time,
	input logic out_valid,
	input logic out_ready,
	input logic accepted,
	input logic got_item,
	input logic [PAYLOAD_W-1:0] out_payload,
	input logic [1:0] out_priority,
	input logic overload,
	input logic [DEPTH_W-1:0] depth_total,
	output int mismatch_count,
	output int outstanding
);

	typedef struct packed {
		logic stored;
		logic served;
		logic [PAYLOAD_W-1:0] word;
		logic [1:0] level;
		logic busy;
		logic [DEPTH_W-1:0] depth;
	} inbox_reply_t;

	logic [DEPTH_W-1:0] depth_limit;
	logic [DEPTH_W-1:0] watermark;
	logic [IVL_W-1:0] fair_span;
	logic [PAYLOAD_W-1:0] lane_mem [3][QUEUE_DEPTH];
	int lane_head [3];
	int lane_count [3];
	logic [TIME_W-1:0] last_served;
	logic overload_state;
	inbox_reply_t replies_due [$];
	inbox_reply_t seen_reply;
	inbox_reply_t due_reply;
	int fail_tally = 0;

	assign mismatch_count = fail_tally;

	function automatic int queued_total();
		return lane_count[0] + lane_count[1] + lane_count[2];
	endfunction

	function automatic void lane_put(int lvl, logic [PAYLOAD_W-1:0] word);
		lane_mem[lvl][(lane_head[lvl] + lane_count[lvl]) % QUEUE_DEPTH] = word;
		lane_count[lvl]++;
	endfunction

	function automatic logic [PAYLOAD_W-1:0] lane_take(int lvl);
		logic [PAYLOAD_W-1:0] word;
		word = lane_mem[lvl][lane_head[lvl]];
		lane_head[lvl] = (lane_head[lvl] + 1) % QUEUE_DEPTH;
		lane_count[lvl]--;
		return word;
	endfunction

	function automatic inbox_reply_t predict_reply(logic fn, logic [1:0] prio,
			logic [PAYLOAD_W-1:0] word, logic [TIME_W-1:0] stamp);
		inbox_reply_t r;
		int total;
		int lvl;
		int alt;
		logic [PAYLOAD_W-1:0] taken;
		r = '0;
		taken = '0;
		total = queued_total();
		if (fn == FUNC_PUSH) begin
			lvl = (prio == PRIO_INVALID) ? int'(LVL_NORMAL) : int'(prio);
			if (total >= int'(depth_limit)) begin
				overload_state = 1'b1;
			end else begin
				if (total < int'(watermark))
					overload_state = 1'b0;
				if (lane_count[lvl] < QUEUE_DEPTH) begin
					lane_put(lvl, word);
					r.stored = 1'b1;
				end
			end
		end else begin
			lvl = -1;
			if (lane_count[LVL_HIGH] != 0) begin
				taken = lane_take(LVL_HIGH);
				lvl = LVL_HIGH;
				if (last_served != '0 && stamp >= last_served &&
						(stamp - last_served) >= TIME_W'(fair_span)) begin
					alt = (lane_count[LVL_NORMAL] != 0) ? int'(LVL_NORMAL) :
						(lane_count[LVL_LOW] != 0) ? int'(LVL_LOW) : -1;
					if (alt >= 0) begin
						lane_put(LVL_HIGH, taken);
						taken = lane_take(alt);
						lvl = alt;
					end
				end
			end else if (lane_count[LVL_NORMAL] != 0) begin
				taken = lane_take(LVL_NORMAL);
				lvl = LVL_NORMAL;
			end else if (lane_count[LVL_LOW] != 0) begin
				taken = lane_take(LVL_LOW);
				lvl = LVL_LOW;
			end
			if (lvl >= 0) begin
				last_served = stamp;
				r.served = 1'b1;
				r.word = taken;
				r.level = 2'(lvl);
			end
		end
		r.busy = overload_state;
		r.depth = DEPTH_W'(queued_total());
		return r;
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			fail_tally++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_limit = MAX_DEPTH_RST;
			watermark = LOW_WMARK_RST;
			fair_span = FAIR_IVL_RST;
			for (int i = 0; i < 3; i++) begin
				lane_head[i] = 0;
				lane_count[i] = 0;
			end
			last_served = '0;
			overload_state = 1'b0;
			replies_due.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MAX_DEPTH: depth_limit = cfg_data[DEPTH_W-1:0];
					CFG_LOW_WMARK: watermark = cfg_data[DEPTH_W-1:0];
					CFG_FAIR_IVL: fair_span = cfg_data[IVL_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				seen_reply = '{accepted, got_item, out_payload, out_priority, overload,
					depth_total};
				if (replies_due.size() == 0) begin
					$error("result beat arrived with no request outstanding");
					fail_tally++;
				end else begin
					due_reply = replies_due.pop_front();
					check_field("accepted", 64'(due_reply.stored), 64'(seen_reply.stored));
					check_field("got_item", 64'(due_reply.served), 64'(seen_reply.served));
					check_field("out_payload", 64'(due_reply.word), 64'(seen_reply.word));
					check_field("out_priority", 64'(due_reply.level), 64'(seen_reply.level));
					check_field("overload", 64'(due_reply.busy), 64'(seen_reply.busy));
					check_field("depth_total", 64'(due_reply.depth), 64'(seen_reply.depth));
				end
			end
			if (in_valid && in_ready)
				replies_due.push_back(predict_reply(func, priority_req, payload, now_time));
			outstanding <= replies_due.size();
		end
	end

endmodule

### test/three_level_priority_inbox_test.sv
`timescale 1ns / 100ps

module three_level_priority_inbox_test;
	import tlpi_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int FIRST_MODE_END = 470;
	localparam int SECOND_MODE_END = 940;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic func = FUNC_PUSH;
	logic [1:0] priority_req = LVL_HIGH;
	logic [PAYLOAD_W-1:0] payload = '0;
	logic [TIME_W-1:0] now_time = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic accepted;
	logic got_item;
	logic [PAYLOAD_W-1:0] out_payload;
	logic [1:0] out_priority;
	logic overload;
	logic [DEPTH_W-1:0] depth_total;

	int mismatch_count;
	int outstanding;
	int stall_cycles = 0;
	int beats_sent = 0;
	int send_idle_pct = 34;
	int recv_idle_pct = 85;
	logic [TIME_W-1:0] clock_now = '0;

	three_level_priority_inbox u_top (.*);

	three_level_priority_inbox_checker u_check (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			stall_cycles <= 0;
		else if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	task automatic send_beat(input logic fn, input logic [1:0] prio,
			input logic [PAYLOAD_W-1:0] word, input logic [TIME_W-1:0] stamp);
		if (beats_sent < FIRST_MODE_END) begin
			send_idle_pct = 34;
			recv_idle_pct = 85;
		end else if (beats_sent < SECOND_MODE_END) begin
			send_idle_pct = 85;
			recv_idle_pct = 34;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= fn;
		priority_req <= prio;
		payload <= word;
		now_time <= stamp;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_settings(input logic [DEPTH_W-1:0] depth_cap,
			input logic [DEPTH_W-1:0] clear_level, input logic [IVL_W-1:0] span);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_MAX_DEPTH;
		cfg_data <= CFG_DATA_W'(depth_cap);
		@(posedge clk);
		cfg_index <= CFG_LOW_WMARK;
		cfg_data <= CFG_DATA_W'(clear_level);
		@(posedge clk);
		cfg_index <= CFG_FAIR_IVL;
		cfg_data <= span;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly a slowly advancing clock, with jumps, rewinds, zero and the top value.
	function automatic logic [TIME_W-1:0] next_stamp(int step_max);
		int r;
		r = $urandom_range(99);
		if (r < 3)
			clock_now = TIME_W'({$urandom, $urandom});
		else if (r < 5)
			clock_now = clock_now - TIME_W'($urandom_range(step_max * 4));
		else if (r == 5)
			clock_now = '0;
		else if (r == 6)
			clock_now = '1;
		else
			clock_now = clock_now + TIME_W'($urandom_range(step_max, 1));
		return clock_now;
	endfunction

	task automatic run_traffic(int count, int push_pct, int high_pct, int step_max);
		logic fn;
		logic [1:0] prio;
		for (int i = 0; i < count; i++) begin
			fn = ($urandom_range(99) < push_pct) ? FUNC_PUSH : FUNC_POP;
			if ($urandom_range(99) < high_pct)
				prio = LVL_HIGH;
			else
				prio = 2'($urandom_range(3, 1));
			send_beat(fn, prio, $urandom, next_stamp(step_max));
			if ($urandom_range(199) == 0)
				wait_drained();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(FUNC_POP, LVL_HIGH, 32'h0, 63'd5);
		send_beat(FUNC_PUSH, LVL_HIGH, 32'h0000_0000, 63'd0);
		send_beat(FUNC_PUSH, LVL_HIGH, 32'hFFFF_FFFF, 63'd0);
		send_beat(FUNC_PUSH, LVL_HIGH, 32'h1234_5678, 63'd0);
		send_beat(FUNC_PUSH, LVL_NORMAL, 32'hA5A5_A5A5, 63'd0);
		send_beat(FUNC_PUSH, PRIO_INVALID, 32'h5A5A_5A5A, 63'd0);
		send_beat(FUNC_PUSH, LVL_LOW, 32'h0000_0001, 63'd0);
		send_beat(FUNC_POP, LVL_HIGH, 32'h0, 63'd0);
		send_beat(FUNC_POP, LVL_NORMAL, 32'h0, 63'd200_000_000);
		send_beat(FUNC_POP, LVL_LOW, 32'h0, 63'd100);
		send_beat(FUNC_PUSH, LVL_HIGH, 32'hCAFE_F00D, 63'd0);
		send_beat(FUNC_POP, PRIO_INVALID, 32'hFFFF_FFFF, 63'd100_000_100);
		send_beat(FUNC_POP, LVL_HIGH, 32'h0, '1);
		send_beat(FUNC_POP, LVL_HIGH, 32'h0, '1);
		send_beat(FUNC_PUSH, LVL_HIGH, 32'h0000_0077, '1);
		send_beat(FUNC_POP, LVL_HIGH, 32'h0, 63'd0);
		send_beat(FUNC_POP, LVL_HIGH, 32'h0, 63'd0);
		send_beat(FUNC_PUSH, LVL_HIGH, 32'h0000_0088, 63'd0);
		send_beat(FUNC_POP, LVL_HIGH, 32'h0, 63'd1);
		send_beat(FUNC_PUSH, LVL_HIGH, 32'h0000_0099, 63'd0);
		send_beat(FUNC_POP, LVL_HIGH, 32'h0, 63'd2_000_000_000);
		send_beat(FUNC_POP, LVL_HIGH, 32'h0, 63'd2_000_000_001);

		write_settings(10'd4, 10'd2, 40'd0);
		run_traffic(250, 60, 35, 8);
		write_settings(10'd768, 10'd614, 40'd3);
		run_traffic(550, 90, 80, 4);
		write_settings(10'd1023, 10'd768, 40'hFF_FFFF_FFFF);
		run_traffic(180, 30, 80, 1000);
		write_settings(10'd0, 10'd0, 40'd1);
		run_traffic(50, 60, 30, 3);
		write_settings(10'd1, 10'd1, 40'd7);
		run_traffic(50, 60, 30, 5);
		write_settings(10'd40, 10'd30, 40'd50);
		run_traffic(300, 55, 40, 20);

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### filelist.f
src/tlpi_pkg.sv
src/tlpi_front.sv
src/tlpi_back.sv
src/three_level_priority_inbox.sv
test/three_level_priority_inbox_checker.sv
test/three_level_priority_inbox_test.sv
